// File: hdl/cch_pkg.sv
// Shared types, constants and helper functions for the compass heading block.
// No dependencies; every other file refers to this package by scoped names.
package cch_pkg;

	localparam int SAMPLE_W         = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF  = 2;
	localparam int ANG_TABLE_LEN    = 24;
	localparam int ANG_IDX_W        = 5;
	// Scaled vector: 17-bit magnitude << 16, plus CORDIC gain and sign headroom.
	localparam int CORDIC_W         = 36;
	// Angle accumulator in 1/256 hundredth of a degree.
	localparam int ANGLE_W          = 25;

	localparam logic signed [ANGLE_W-1:0]  HALF_TURN_Q8 = 25'sd4608000;
	localparam logic signed [ANGLE_W-1:0]  ROUND_Q8     = 25'sd128;
	localparam logic signed [SAMPLE_W-1:0] HALF_TURN    = 16'sd18000;
	localparam logic signed [16:0]         FULL_TURN    = 17'sd36000;
	localparam logic signed [16:0]         WRAP_MAX     = 17'sd35999;

	typedef enum logic [1:0] {
		OP_SEED    = 2'd0,
		OP_SAMPLE  = 2'd1,
		OP_FINISH  = 2'd2,
		OP_MEASURE = 2'd3
	} opcode_t;

	typedef enum logic {
		KIND_HEADING = 1'b0,
		KIND_OFFSET  = 1'b1
	} result_kind_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Work item handed from the front to the back: offsets for a finish,
	// raw sample for a measurement.
	typedef struct packed {
		result_kind_t kind;
		sample_t      x;
		sample_t      y;
		sample_t      z;
	} job_t;

	function automatic logic signed [ANGLE_W-1:0] atan_q8(input logic [ANG_IDX_W-1:0] idx);
		logic signed [ANGLE_W-1:0] v;
		case (idx)
			5'd0:    v = 25'sd1152000;
			5'd1:    v = 25'sd680065;
			5'd2:    v = 25'sd359328;
			5'd3:    v = 25'sd182400;
			5'd4:    v = 25'sd91554;
			5'd5:    v = 25'sd45822;
			5'd6:    v = 25'sd22916;
			5'd7:    v = 25'sd11459;
			5'd8:    v = 25'sd5730;
			5'd9:    v = 25'sd2865;
			5'd10:   v = 25'sd1432;
			5'd11:   v = 25'sd716;
			5'd12:   v = 25'sd358;
			5'd13:   v = 25'sd179;
			5'd14:   v = 25'sd90;
			5'd15:   v = 25'sd45;
			5'd16:   v = 25'sd22;
			5'd17:   v = 25'sd11;
			5'd18:   v = 25'sd6;
			5'd19:   v = 25'sd3;
			5'd20:   v = 25'sd1;
			5'd21:   v = 25'sd1;
			default: v = 25'sd0;
		endcase
		return v;
	endfunction

	// min + (max - min) / 2, division truncated toward zero, wrapped to 16 bits.
	function automatic sample_t offset_mid(input sample_t lo, input sample_t hi);
		logic signed [16:0] diff;
		logic signed [16:0] bias;
		logic signed [16:0] half;
		logic signed [16:0] sum;
		diff = 17'(hi) - 17'(lo);
		bias = diff + {16'b0, diff[16]};
		half = bias >>> 1;
		sum  = 17'(lo) + half;
		return sum[SAMPLE_W-1:0];
	endfunction

endpackage

// File: hdl/cch_ifs.sv
// Handshake channels of the compass heading block: sample input, result
// output and the internal job channel. Depends on cch_pkg.
interface cch_in_if;
	logic                   valid;
	logic                   ready;
	logic [1:0]             opcode;
	cch_pkg::sample_t       mag_x;
	cch_pkg::sample_t       mag_y;
	cch_pkg::sample_t       mag_z;
	modport source (output valid, opcode, mag_x, mag_y, mag_z, input ready);
	modport sink   (input valid, opcode, mag_x, mag_y, mag_z, output ready);
endinterface

interface cch_out_if;
	logic                   valid;
	logic                   ready;
	logic                   result_kind;
	logic [15:0]            heading_wrapped;
	logic signed [15:0]     heading_xy;
	logic signed [15:0]     heading_zx;
	cch_pkg::sample_t       offset_x;
	cch_pkg::sample_t       offset_y;
	cch_pkg::sample_t       offset_z;
	modport source (output valid, result_kind, heading_wrapped, heading_xy, heading_zx,
		offset_x, offset_y, offset_z, input ready);
	modport sink   (input valid, result_kind, heading_wrapped, heading_xy, heading_zx,
		offset_x, offset_y, offset_z, output ready);
endinterface

interface cch_job_if;
	logic                   valid;
	logic                   ready;
	cch_pkg::job_t          job;
	modport source (output valid, job, input ready);
	modport sink   (input valid, job, output ready);
endinterface

// File: hdl/cch_front.sv
// Front end: accepts samples, tracks per-axis min/max and forwards finish and
// measure work as jobs. Depends on cch_pkg and cch_ifs.
module cch_front (
	input  logic         clk,
	input  logic         arst_n,
	cch_in_if.sink       samples,
	cch_job_if.source    push
);

	cch_pkg::sample_t   min_q [3];
	cch_pkg::sample_t   max_q [3];
	cch_pkg::sample_t   smp [3];
	cch_pkg::opcode_t   op;
	logic               is_job;
	logic               accept;

	always_comb begin
		op     = cch_pkg::opcode_t'(samples.opcode);
		smp[0] = samples.mag_x;
		smp[1] = samples.mag_y;
		smp[2] = samples.mag_z;
		is_job = (op == cch_pkg::OP_FINISH) || (op == cch_pkg::OP_MEASURE);
		samples.ready = push.ready;
		accept = samples.valid && samples.ready;
		push.valid = samples.valid && is_job;
		if (op == cch_pkg::OP_FINISH) begin
			push.job.kind = cch_pkg::KIND_OFFSET;
			push.job.x    = cch_pkg::offset_mid(min_q[0], max_q[0]);
			push.job.y    = cch_pkg::offset_mid(min_q[1], max_q[1]);
			push.job.z    = cch_pkg::offset_mid(min_q[2], max_q[2]);
		end else begin
			push.job.kind = cch_pkg::KIND_HEADING;
			push.job.x    = smp[0];
			push.job.y    = smp[1];
			push.job.z    = smp[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				min_q[k] <= '0;
				max_q[k] <= '0;
			end
		end else if (accept) begin
			case (op)
				cch_pkg::OP_SEED: begin
					for (int k = 0; k < 3; k++) begin
						min_q[k] <= smp[k];
						max_q[k] <= smp[k];
					end
				end
				cch_pkg::OP_SAMPLE: begin
					// lower the min, otherwise raise the max
					for (int k = 0; k < 3; k++) begin
						if (min_q[k] > smp[k])
							min_q[k] <= smp[k];
						else if (max_q[k] < smp[k])
							max_q[k] <= smp[k];
					end
				end
				default: ;
			endcase
		end
	end

	a_seed_collapses: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && samples.opcode == cch_pkg::OP_SEED) |=>
		(min_q[0] == max_q[0] && min_q[1] == max_q[1] && min_q[2] == max_q[2]))
		else $error("seed did not load min and max alike");

endmodule

// File: hdl/cch_queue.sv
// Short job queue between front and back so each side stalls on its own.
// Depends on cch_pkg and cch_ifs.
module cch_queue #(
	parameter int DEPTH = cch_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	cch_job_if.sink      push,
	cch_job_if.source    pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cch_pkg::job_t      mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	always_comb begin
		push.ready = (count_q != CNT_FULL);
		pop.valid  = (count_q != '0);
		pop.job    = mem_q[rd_ptr_q];
		do_push    = push.valid && push.ready;
		do_pop     = pop.valid && pop.ready;
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push.job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue fill count beyond depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue empty with pointers apart");

endmodule

// File: hdl/cch_back.sv
// Back end: latches offsets on finish, runs two iterative CORDIC passes per
// measurement and drives the registered result. Depends on cch_pkg, cch_ifs.
module cch_back #(
	parameter int CORDIC_STEPS = cch_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	cch_job_if.sink      pop,
	cch_out_if.source    results
);

	localparam int NSTEPS = (CORDIC_STEPS < cch_pkg::ANG_TABLE_LEN) ?
		CORDIC_STEPS : cch_pkg::ANG_TABLE_LEN;
	localparam int CNT_W  = $clog2(NSTEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NSTEPS - 1);
	localparam int CW = cch_pkg::CORDIC_W;
	localparam int AW = cch_pkg::ANGLE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_ITER,
		S_ROUND,
		S_EMIT
	} state_t;

	state_t                 state_q;
	logic                   pass_q;
	logic [CNT_W-1:0]       cnt_q;
	cch_pkg::result_kind_t  kind_q;
	cch_pkg::sample_t       off_q [3];
	cch_pkg::sample_t       cx_q, cy_q, cz_q;
	logic signed [CW-1:0]   x_q, y_q;
	logic signed [AW-1:0]   z_q;
	logic signed [15:0]     hxy_q, hzx_q;
	logic                   out_valid_q;
	logic                   out_kind_q;
	logic [15:0]            out_wrapped_q;
	logic signed [15:0]     out_hxy_q, out_hzx_q;
	cch_pkg::sample_t       out_off_q [3];

	cch_pkg::sample_t       a_sel, b_sel;
	logic signed [16:0]     a_mag, b_mag;
	logic signed [CW-1:0]   x_init, y_init;
	logic signed [AW-1:0]   z_init;
	logic signed [CW-1:0]   xs, ys, x_nx, y_nx;
	logic signed [AW-1:0]   z_nx, z_abs, t_q8;
	logic signed [15:0]     t_sat;
	logic signed [16:0]     wrap_sum;
	logic [15:0]            wrapped;
	logic                   out_free;

	always_comb begin
		a_sel = pass_q ? cz_q : cx_q;
		b_sel = pass_q ? cx_q : cy_q;
		if (b_sel < 0) begin
			a_mag  = -17'(a_sel);
			b_mag  = -17'(b_sel);
			z_init = (a_sel > 0) ? cch_pkg::HALF_TURN_Q8 : -cch_pkg::HALF_TURN_Q8;
		end else begin
			a_mag  = 17'(a_sel);
			b_mag  = 17'(b_sel);
			z_init = '0;
		end
		x_init = CW'(b_mag) <<< 16;
		y_init = CW'(a_mag) <<< 16;

		xs = x_q >>> cnt_q;
		ys = y_q >>> cnt_q;
		if (!y_q[CW-1]) begin
			x_nx = x_q + ys;
			y_nx = y_q - xs;
			z_nx = z_q + cch_pkg::atan_q8(cch_pkg::ANG_IDX_W'(cnt_q));
		end else begin
			x_nx = x_q - ys;
			y_nx = y_q + xs;
			z_nx = z_q - cch_pkg::atan_q8(cch_pkg::ANG_IDX_W'(cnt_q));
		end

		// round half away from zero, then saturate to a half turn
		z_abs = -z_q;
		if (!z_q[AW-1])
			t_q8 = (z_q + cch_pkg::ROUND_Q8) >>> 8;
		else
			t_q8 = -((z_abs + cch_pkg::ROUND_Q8) >>> 8);
		if (t_q8 > AW'(cch_pkg::HALF_TURN))
			t_sat = cch_pkg::HALF_TURN;
		else if (t_q8 < -AW'(cch_pkg::HALF_TURN))
			t_sat = -cch_pkg::HALF_TURN;
		else
			t_sat = t_q8[15:0];

		wrap_sum = hxy_q[15] ? (17'(hxy_q) + cch_pkg::FULL_TURN) : 17'(hxy_q);
		if (wrap_sum > cch_pkg::WRAP_MAX)
			wrapped = cch_pkg::WRAP_MAX[15:0];
		else if (wrap_sum < 0)
			wrapped = '0;
		else
			wrapped = wrap_sum[15:0];

		out_free  = !out_valid_q || results.ready;
		pop.ready = (state_q == S_IDLE);

		results.valid           = out_valid_q;
		results.result_kind     = out_kind_q;
		results.heading_wrapped = out_wrapped_q;
		results.heading_xy      = out_hxy_q;
		results.heading_zx      = out_hzx_q;
		results.offset_x        = out_off_q[0];
		results.offset_y        = out_off_q[1];
		results.offset_z        = out_off_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (results.valid && results.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop.valid) begin
						pass_q  <= 1'b0;
						state_q <= (pop.job.kind == cch_pkg::KIND_OFFSET) ? S_EMIT : S_INIT;
					end
				end
				S_INIT: begin
					cnt_q   <= '0;
					state_q <= (a_sel == '0) ? S_ROUND : S_ITER;
				end
				S_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST)
						state_q <= S_ROUND;
				end
				S_ROUND: begin
					pass_q  <= 1'b1;
					state_q <= pass_q ? S_EMIT : S_INIT;
				end
				S_EMIT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// latched offsets reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++)
				off_q[k] <= '0;
		end else if (state_q == S_IDLE && pop.valid
				&& pop.job.kind == cch_pkg::KIND_OFFSET) begin
			off_q[0] <= pop.job.x;
			off_q[1] <= pop.job.y;
			off_q[2] <= pop.job.z;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (pop.valid) begin
					kind_q <= pop.job.kind;
					hxy_q  <= '0;
					hzx_q  <= '0;
					cx_q   <= pop.job.x - off_q[0];
					cy_q   <= pop.job.y - off_q[1];
					cz_q   <= pop.job.z - off_q[2];
				end
			end
			S_INIT: begin
				if (a_sel == '0) begin
					z_q <= (b_sel < 0) ? cch_pkg::HALF_TURN_Q8 : '0;
				end else begin
					x_q <= x_init;
					y_q <= y_init;
					z_q <= z_init;
				end
			end
			S_ITER: begin
				x_q <= x_nx;
				y_q <= y_nx;
				z_q <= z_nx;
			end
			S_ROUND: begin
				if (pass_q)
					hzx_q <= t_sat;
				else
					hxy_q <= t_sat;
			end
			S_EMIT: begin
				if (out_free) begin
					out_kind_q    <= kind_q;
					out_wrapped_q <= wrapped;
					out_hxy_q     <= hxy_q;
					out_hzx_q     <= hzx_q;
					for (int k = 0; k < 3; k++)
						out_off_q[k] <= off_q[k];
				end
			end
			default: ;
		endcase
	end

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER) |-> (cnt_q <= CNT_LAST))
		else $error("CORDIC step count overran");

	a_offset_report_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.result_kind == cch_pkg::KIND_OFFSET) |->
		(results.heading_xy == '0 && results.heading_zx == '0
			&& results.heading_wrapped == '0))
		else $error("offset report carries a heading");

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_EMIT))
		else $error("result raised outside the emit state");

endmodule

// File: hdl/compass_calibrate_heading.sv
// Results: seed and calibration beats give no result; finish and measure beats give one each.
// Throughput: the back runs the shared one-step-a-cycle CORDIC twice per measurement and
//   takes no new job until it has emitted its result; seed and calibration beats at one a
//   cycle while the queue has room.
// Reset: arst_n clears min, max and offsets to zero and empties the job queue.
module compass_calibrate_heading #(
	parameter int CORDIC_STEPS = cch_pkg::CORDIC_STEPS_DEF,
	parameter int QUEUE_DEPTH  = cch_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	cch_in_if.sink       samples,
	cch_out_if.source    results
);

	// Job channels: front into the queue, queue into the back.
	cch_job_if front_jobs ();
	cch_job_if back_jobs ();

	// Front: classify each beat. Seed and calibration beats update the
	// min/max registers on the spot and stop there; a finish beat computes
	// the mid-range offsets from the current min/max and a measure beat
	// carries its raw sample, both as one job each. Input ready follows the
	// queue's room only, so a waiting result holds the front only once the queue fills.
	cch_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.push    (front_jobs.source)
	);

	// Queue: hold jobs in order while the back is busy with a CORDIC run.
	// Ordering through this queue keeps each measurement paired with the
	// offsets latched by the last finish before it.
	cch_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_jobs.sink),
		.pop    (back_jobs.source)
	);

	// Back: latch offsets on a finish job and report them; on a measure job
	// subtract the offsets with 16-bit wrap, run the vectoring CORDIC once for
	// the x/y heading and once for z/x, round to hundredths and drive the
	// result from an output register that decouples it from the next job.
	cch_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.pop     (back_jobs.sink),
		.results (results)
	);

endmodule

// File: tb/sv/heading_check_pkg.sv
// Predictor and result scoreboard for the compass heading testbench.
// Depends on cch_pkg for the opcode, result kind and sample types.
package heading_check_pkg;

	localparam int     STEPS          = cch_pkg::CORDIC_STEPS_DEF;
	localparam int     ATAN_ENTRIES   = 24;
	localparam longint HALF_TURN_FINE = 64'sd4608000;

	// arctan(2^-i) in 1/256 hundredth of a degree
	localparam longint ATAN_STEP_Q8 [ATAN_ENTRIES] = '{
		1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
		5730, 2865, 1432, 716, 358, 179, 90, 45,
		22, 11, 6, 3, 1, 1, 0, 0
	};

	typedef struct packed {
		logic               kind;
		logic [15:0]        wrapped;
		logic signed [15:0] xy;
		logic signed [15:0] zx;
		logic signed [15:0] ox;
		logic signed [15:0] oy;
		logic signed [15:0] oz;
	} heading_report_t;

	class heading_tracker;
		cch_pkg::sample_t cal_min [3];
		cch_pkg::sample_t cal_max [3];
		cch_pkg::sample_t hard_offset [3];
		heading_report_t  pending [$];
		int               mismatches;

		function new();
			for (int k = 0; k < 3; k++) begin
				cal_min[k]     = '0;
				cal_max[k]     = '0;
				hard_offset[k] = '0;
			end
			mismatches = 0;
		endfunction

		// vectoring CORDIC atan2(a, b) in hundredths of a degree
		function int angle_centideg(int a, int b);
			longint vx;
			longint vy;
			longint ang;
			longint vxs;
			longint vys;
			longint rounded;
			int     step;
			if (a == 0)
				return (b < 0) ? 18000 : 0;
			ang = 0;
			if (b < 0) begin
				ang = (a > 0) ? HALF_TURN_FINE : -HALF_TURN_FINE;
				a   = -a;
				b   = -b;
			end
			vx = longint'(b) * 65536;
			vy = longint'(a) * 65536;
			for (step = 0; step < STEPS && step < ATAN_ENTRIES; step++) begin
				vxs = vx >>> step;
				vys = vy >>> step;
				if (vy >= 0) begin
					vx  = vx + vys;
					vy  = vy - vxs;
					ang = ang + ATAN_STEP_Q8[step];
				end else begin
					vx  = vx - vys;
					vy  = vy + vxs;
					ang = ang - ATAN_STEP_Q8[step];
				end
			end
			if (ang >= 0)
				rounded = (ang + 128) >>> 8;
			else
				rounded = -((-ang + 128) >>> 8);
			if (rounded > 18000)
				rounded = 18000;
			if (rounded < -18000)
				rounded = -18000;
			return int'(rounded);
		endfunction

		function void take_beat(cch_pkg::opcode_t op, cch_pkg::sample_t x,
				cch_pkg::sample_t y, cch_pkg::sample_t z);
			cch_pkg::sample_t raw [3];
			cch_pkg::sample_t corr [3];
			heading_report_t  rep;
			int               span;
			int               hxy;
			int               hzx;
			int               hw;
			raw[0] = x;
			raw[1] = y;
			raw[2] = z;
			case (op)
				cch_pkg::OP_SEED: begin
					for (int k = 0; k < 3; k++) begin
						cal_min[k] = raw[k];
						cal_max[k] = raw[k];
					end
				end
				cch_pkg::OP_SAMPLE: begin
					for (int k = 0; k < 3; k++) begin
						if (cal_min[k] > raw[k])
							cal_min[k] = raw[k];
						else if (cal_max[k] < raw[k])
							cal_max[k] = raw[k];
					end
				end
				cch_pkg::OP_FINISH: begin
					for (int k = 0; k < 3; k++) begin
						span           = int'(cal_max[k]) - int'(cal_min[k]);
						hard_offset[k] = cch_pkg::sample_t'(int'(cal_min[k]) + span / 2);
					end
					rep.kind    = cch_pkg::KIND_OFFSET;
					rep.wrapped = '0;
					rep.xy      = '0;
					rep.zx      = '0;
				end
				default: begin
					for (int k = 0; k < 3; k++)
						corr[k] = cch_pkg::sample_t'(int'(raw[k]) - int'(hard_offset[k]));
					hxy = angle_centideg(int'(corr[0]), int'(corr[1]));
					hzx = angle_centideg(int'(corr[2]), int'(corr[0]));
					hw  = (hxy < 0) ? hxy + 36000 : hxy;
					if (hw > 35999)
						hw = 35999;
					if (hw < 0)
						hw = 0;
					rep.kind    = cch_pkg::KIND_HEADING;
					rep.wrapped = 16'(hw);
					rep.xy      = 16'(hxy);
					rep.zx      = 16'(hzx);
				end
			endcase
			if (op == cch_pkg::OP_FINISH || op == cch_pkg::OP_MEASURE) begin
				rep.ox = hard_offset[0];
				rep.oy = hard_offset[1];
				rep.oz = hard_offset[2];
				pending.push_back(rep);
			end
		endfunction

		function void compare_field(string label, logic [15:0] want, logic [15:0] got,
				realtime stamp);
			if (got !== want) begin
				mismatches++;
				$display("t=%0t %s mismatch: expected %h actual %h",
					stamp, label, want, got);
			end
		endfunction

		function void match_report(heading_report_t got, realtime stamp);
			heading_report_t want;
			if (pending.size() == 0) begin
				mismatches++;
				$display("t=%0t unexpected result: expected none actual %h", stamp, got);
				return;
			end
			want = pending.pop_front();
			compare_field("result_kind", 16'(want.kind), 16'(got.kind), stamp);
			compare_field("heading_wrapped", want.wrapped, got.wrapped, stamp);
			compare_field("heading_xy", want.xy, got.xy, stamp);
			compare_field("heading_zx", want.zx, got.zx, stamp);
			compare_field("offset_x", want.ox, got.ox, stamp);
			compare_field("offset_y", want.oy, got.oy, stamp);
			compare_field("offset_z", want.oz, got.oz, stamp);
		endfunction
	endclass

endpackage

// File: tb/sv/tb.sv
// Top-level testbench of compass_calibrate_heading: drives sample beats, stalls
// the result side and checks every report against heading_check_pkg's predictor.
// Depends on cch_pkg, the channel interfaces and heading_check_pkg.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import heading_check_pkg::*;

	localparam int          CORDIC_STEPS = cch_pkg::CORDIC_STEPS_DEF;
	localparam int          RANDOM_BEATS = 1400;
	// drain margin: one measurement plus slack
	localparam int          DRAIN_CYCLES = 2 * CORDIC_STEPS + 20;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	logic clk = 1'b0;
	logic arst_n;

	cch_in_if  samples_bus ();
	cch_out_if results_bus ();

	compass_calibrate_heading #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_bus.sink),
		.results(results_bus.source)
	);

	heading_tracker tracker;
	int             beats_sent;
	int             burst_left;
	int unsigned    cycle_count;
	int             ready_mode;
	int             ready_phase;
	logic [7:0]     stall_mask;

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop: count cycles and give up well past the slowest legal run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Receiver stalls: pick a new pattern style whenever ready_phase wraps to zero, so stalls
	// land on every phase of the CORDIC run, with stretches of constant ready.
	always @(posedge clk) begin
		if (ready_phase == 0) begin
			ready_mode = $urandom_range(0, 3);
			stall_mask = 8'($urandom_range(0, 255));
		end
		ready_phase = (ready_phase + 1) % 48;
		case (ready_mode)
			0:       results_bus.ready <= 1'b1;
			1:       results_bus.ready <= 1'($urandom_range(0, 1));
			2:       results_bus.ready <= stall_mask[ready_phase % 8];
			default: results_bus.ready <= ($urandom_range(0, 4) != 0);
		endcase
	end

	// Result monitor: compare each accepted beat with the oldest pending report.
	always @(posedge clk) begin
		heading_report_t got;
		if (arst_n === 1'b1 && results_bus.valid === 1'b1 && results_bus.ready === 1'b1) begin
			got.kind    = results_bus.result_kind;
			got.wrapped = results_bus.heading_wrapped;
			got.xy      = results_bus.heading_xy;
			got.zx      = results_bus.heading_zx;
			got.ox      = results_bus.offset_x;
			got.oy      = results_bus.offset_y;
			got.oz      = results_bus.offset_z;
			tracker.match_report(got, $realtime);
		end
	end

	function automatic int new_burst_length();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(30, 80);
		return $urandom_range(1, 12);
	endfunction

	// Offer one beat and hold it until the block takes it; then either keep
	// valid high for the next beat of the burst or drop it for a random gap.
	task automatic send_beat(cch_pkg::opcode_t op, cch_pkg::sample_t x,
			cch_pkg::sample_t y, cch_pkg::sample_t z);
		int gap;
		samples_bus.valid  <= 1'b1;
		samples_bus.opcode <= op;
		samples_bus.mag_x  <= x;
		samples_bus.mag_y  <= y;
		samples_bus.mag_z  <= z;
		do
			@(posedge clk);
		while (samples_bus.ready !== 1'b1);
		tracker.take_beat(op, x, y, z);
		beats_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				samples_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = new_burst_length();
		end
	endtask

	function automatic cch_pkg::sample_t pick_axis();
		case ($urandom_range(0, 9))
			0:       return cch_pkg::sample_t'(-32768);
			1:       return cch_pkg::sample_t'(32767);
			2:       return '0;
			3, 4:    return cch_pkg::sample_t'(int'($urandom_range(0, 600)) - 300);
			default: return cch_pkg::sample_t'(16'($urandom_range(0, 65535)));
		endcase
	endfunction

	// wraps like the block's 16-bit arithmetic
	function automatic cch_pkg::sample_t jitter(cch_pkg::sample_t centre, int spread);
		return cch_pkg::sample_t'(int'(centre) + int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	// One well-formed calibration round with random content: seed, a cloud of
	// samples round a centre, finish, then a run of measurements near the centre.
	task automatic run_calibration_round();
		cch_pkg::sample_t centre [3];
		cch_pkg::sample_t m [3];
		int               spread;
		int               n_cal;
		int               n_meas;
		for (int k = 0; k < 3; k++)
			centre[k] = pick_axis();
		spread = ($urandom_range(0, 3) == 0) ? 30000 : $urandom_range(20, 4000);
		n_cal  = $urandom_range(1, 16);
		n_meas = $urandom_range(1, 12);
		send_beat(cch_pkg::OP_SEED, jitter(centre[0], spread), jitter(centre[1], spread),
			jitter(centre[2], spread));
		repeat (n_cal)
			send_beat(cch_pkg::OP_SAMPLE, jitter(centre[0], spread),
				jitter(centre[1], spread), jitter(centre[2], spread));
		send_beat(cch_pkg::OP_FINISH, pick_axis(), pick_axis(), pick_axis());
		repeat (n_meas) begin
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(0, 7))
					// land exactly on the offset so the corrected axis is zero
					0:       m[k] = tracker.hard_offset[k];
					1:       m[k] = pick_axis();
					default: m[k] = jitter(tracker.hard_offset[k], spread);
				endcase
			end
			send_beat(cch_pkg::OP_MEASURE, m[0], m[1], m[2]);
		end
	endtask

	// Noise and broken sequences: random opcodes in any order.
	task automatic run_noise();
		int n;
		n = $urandom_range(1, 6);
		repeat (n)
			send_beat(cch_pkg::opcode_t'($urandom_range(0, 3)), pick_axis(), pick_axis(),
				pick_axis());
	endtask

	initial begin
		tracker            = new();
		beats_sent         = 0;
		burst_left         = new_burst_length();
		ready_mode         = 0;
		ready_phase        = 0;
		stall_mask         = 8'hff;
		arst_n             = 1'b0;
		samples_bus.valid  = 1'b0;
		samples_bus.opcode = cch_pkg::OP_SEED;
		samples_bus.mag_x  = '0;
		samples_bus.mag_y  = '0;
		samples_bus.mag_z  = '0;
		results_bus.ready  = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Offsets start at zero after reset.
		// Both axes zero: atan2 of a zero vector.
		send_beat(cch_pkg::OP_MEASURE, 16'sd0, 16'sd0, 16'sd0);
		// Finish before any seed: offsets from the reset min and max.
		send_beat(cch_pkg::OP_FINISH, 16'sh1234, -16'sd4321, 16'sd777);
		// Zero numerator with negative denominator gives the half turn.
		send_beat(cch_pkg::OP_MEASURE, 16'sd0, -16'sd100, 16'sd0);
		// Zero denominator, and the zx heading in the fourth quadrant.
		send_beat(cch_pkg::OP_MEASURE, 16'sd100, 16'sd0, -16'sd100);
		// Negative denominator with both numerator signs, full-scale values.
		send_beat(cch_pkg::OP_MEASURE, -16'sd32768, -16'sd32768, 16'sd32767);
		send_beat(cch_pkg::OP_MEASURE, 16'sd32767, -16'sd1, -16'sd32768);
		// Calibration samples without a seed widen the reset range.
		send_beat(cch_pkg::OP_SAMPLE, 16'sd5, 16'sd5, 16'sd5);
		send_beat(cch_pkg::OP_SAMPLE, -16'sd7, -16'sd7, -16'sd7);
		send_beat(cch_pkg::OP_FINISH, 16'sd0, 16'sd0, 16'sd0);
		// Full-scale span: the difference needs the seventeenth bit.
		send_beat(cch_pkg::OP_SEED, -16'sd32768, 16'sd32767, 16'sd0);
		send_beat(cch_pkg::OP_SAMPLE, 16'sd32767, -16'sd32768, -16'sd32768);
		send_beat(cch_pkg::OP_SAMPLE, 16'sd0, 16'sd0, 16'sd32767);
		send_beat(cch_pkg::OP_FINISH, -16'sd1, -16'sd1, -16'sd1);
		// Corrected y wraps past the positive limit.
		send_beat(cch_pkg::OP_MEASURE, -16'sd32768, 16'sd32767, -16'sd32768);
		// Offsets at the positive limit: correction wraps round the bottom.
		send_beat(cch_pkg::OP_SEED, 16'sd32767, 16'sd32767, 16'sd32767);
		send_beat(cch_pkg::OP_FINISH, 16'sd0, 16'sd0, 16'sd0);
		send_beat(cch_pkg::OP_MEASURE, -16'sd32768, -16'sd32768, -16'sd32768);
		send_beat(cch_pkg::OP_MEASURE, 16'sd32767, 16'sd32767, 16'sd32767);
		// Offsets at the negative limit.
		send_beat(cch_pkg::OP_SEED, -16'sd32768, -16'sd32768, -16'sd32768);
		send_beat(cch_pkg::OP_FINISH, 16'sd0, 16'sd0, 16'sd0);
		send_beat(cch_pkg::OP_MEASURE, 16'sd32767, 16'sd0, -16'sd1);
		// Odd spans: halving truncates.
		send_beat(cch_pkg::OP_SEED, -16'sd3, -16'sd2, -16'sd1);
		send_beat(cch_pkg::OP_SAMPLE, 16'sd4, 16'sd1, 16'sd6);
		send_beat(cch_pkg::OP_FINISH, 16'sd0, 16'sd0, 16'sd0);
		send_beat(cch_pkg::OP_MEASURE, 16'sd1500, -16'sd2500, 16'sd9);

		// Random part: mostly well-formed rounds, some noise.
		beats_sent = 0;
		while (beats_sent < RANDOM_BEATS) begin
			if ($urandom_range(0, 9) < 8)
				run_calibration_round();
			else
				run_noise();
		end

		// Drop valid at the edge that took the last beat, drain the pending
		// reports, then watch for strays.
		samples_bus.valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: filelist.f
hdl/cch_pkg.sv
hdl/cch_ifs.sv
hdl/cch_front.sv
hdl/cch_queue.sv
hdl/cch_back.sv
hdl/compass_calibrate_heading.sv
tb/sv/heading_check_pkg.sv
tb/sv/tb.sv
